FILE: hdl/vfb_pkg.sv
// Shared types, register indexes, CORDIC constants and helpers for the
// view frustum bounding box. No dependencies.
package vfb_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int BOX_STAGES        = 8;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [40:0] OUT_MAX     = 41'sd549755813887;
  localparam logic signed [40:0] OUT_MIN     = -41'sd549755813888;

  typedef enum logic [2:0] {
    REG_TAN_H     = 3'd0,
    REG_TAN_V     = 3'd1,
    REG_LAT_MARG  = 3'd2,
    REG_HGT_MARG  = 3'd3,
    REG_VIEW_DIST = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic               negc;
  } cordic_t;

  typedef struct packed {
    logic               vld;
    cordic_t [2:0]      ch;
    logic signed [39:0] cx;
    logic signed [39:0] cy;
    logic signed [39:0] cz;
  } cell_t;

  // Residual angle step per stage, 2^-23 degree.
  function automatic logic signed [31:0] atan_of(input int i);
    case (i)
      0:  atan_of = 32'sd377487360;
      1:  atan_of = 32'sd222843801;
      2:  atan_of = 32'sd117744544;
      3:  atan_of = 32'sd59768969;
      4:  atan_of = 32'sd30000467;
      5:  atan_of = 32'sd15014858;
      6:  atan_of = 32'sd7509261;
      7:  atan_of = 32'sd3754860;
      8:  atan_of = 32'sd1877459;
      9:  atan_of = 32'sd938733;
      10: atan_of = 32'sd469367;
      11: atan_of = 32'sd234683;
      12: atan_of = 32'sd117342;
      13: atan_of = 32'sd58671;
      14: atan_of = 32'sd29335;
      15: atan_of = 32'sd14668;
      16: atan_of = 32'sd7334;
      17: atan_of = 32'sd3667;
      18: atan_of = 32'sd1833;
      19: atan_of = 32'sd917;
      20: atan_of = 32'sd458;
      21: atan_of = 32'sd229;
      22: atan_of = 32'sd115;
      23: atan_of = 32'sd57;
      default: atan_of = 32'sd0;
    endcase
  endfunction

  // Wrap into one turn, fold into +-90 degrees, load the CORDIC start vector.
  function automatic cordic_t cordic_init(input logic signed [16:0] a);
    logic signed [17:0] r;
    logic signed [31:0] t;
    cordic_t            c;
    r = 18'(a);
    c.negc = 1'b0;
    if (r >= 18'sd23040) begin
      r = r - 18'sd46080;
    end else if (r < -18'sd23040) begin
      r = r + 18'sd46080;
    end
    if (r > 18'sd11520) begin
      r = 18'sd23040 - r;
      c.negc = 1'b1;
    end else if (r < -18'sd11520) begin
      r = -18'sd23040 - r;
      c.negc = 1'b1;
    end
    t = 32'(r);
    c.z = t <<< 16;
    c.x = CORDIC_GAIN;
    c.y = 33'sd0;
    return c;
  endfunction

  function automatic logic signed [63:0] min4(input logic signed [63:0] a, b, c, d);
    logic signed [63:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    if (d < m) m = d;
    return m;
  endfunction

  function automatic logic signed [63:0] max4(input logic signed [63:0] a, b, c, d);
    logic signed [63:0] m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    if (d > m) m = d;
    return m;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    if (v > OUT_MAX) return OUT_MAX[39:0];
    if (v < OUT_MIN) return OUT_MIN[39:0];
    return v[39:0];
  endfunction

endpackage

FILE: hdl/vfb_cell.sv
// One CORDIC rotation step for the three pose angles, registered.
// Depends on vfb_pkg.
module vfb_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  vfb_pkg::cell_t cin,
  output vfb_pkg::cell_t cout
);
  import vfb_pkg::*;

  localparam logic signed [31:0] ATAN = atan_of(IDX);

  always_ff @(posedge clk) begin
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    for (int k = 0; k < 3; k++) begin
      dx = cin.ch[k].y >>> IDX;
      dy = cin.ch[k].x >>> IDX;
      // zero residual counts as positive
      if (cin.ch[k].z >= 32'sd0) begin
        cout.ch[k].x <= cin.ch[k].x - dx;
        cout.ch[k].y <= cin.ch[k].y + dy;
        cout.ch[k].z <= cin.ch[k].z - ATAN;
      end else begin
        cout.ch[k].x <= cin.ch[k].x + dx;
        cout.ch[k].y <= cin.ch[k].y - dy;
        cout.ch[k].z <= cin.ch[k].z + ATAN;
      end
      cout.ch[k].negc <= cin.ch[k].negc;
    end
    cout.cx <= cin.cx;
    cout.cy <= cin.cy;
    cout.cz <= cin.cz;
    if (rst) begin
      cout.vld <= 1'b0;
    end else begin
      cout.vld <= cin.vld;
    end
  end

endmodule

FILE: hdl/vfb_box.sv
// Sine/cosine rounding, rotation matrix terms, frustum corners, extrema
// and saturated world bounds, eight register stages. Depends on vfb_pkg.
module vfb_box (
  input  logic               clk,
  input  logic               rst,
  input  vfb_pkg::cell_t     cin,
  input  logic [16:0]        tan_h,
  input  logic [16:0]        tan_v,
  input  logic [23:0]        lateral_margin,
  input  logic [23:0]        height_margin,
  input  logic [23:0]        view_distance,
  output logic               done,
  output logic signed [39:0] x_low,
  output logic signed [39:0] x_high,
  output logic signed [39:0] y_low,
  output logic signed [39:0] y_high,
  output logic signed [39:0] z_low,
  output logic signed [39:0] z_high
);
  import vfb_pkg::*;

  logic [BOX_STAGES-1:0] vld;
  logic signed [39:0] cxd [0:BOX_STAGES-2];
  logic signed [39:0] cyd [0:BOX_STAGES-2];
  logic signed [39:0] czd [0:BOX_STAGES-2];

  // stage 1: sines and cosines, Q16 (z = azimuth, y = roll, x = pitch)
  logic signed [18:0] sz, cz, sy, cy, sx, cx;
  // stage 2
  logic signed [37:0] czcy, szcy, szsx, czsx, szcx, czcx;
  logic signed [18:0] sy2;
  // stage 3
  logic signed [37:0] czcy3, szcy3, szcx3, czcx3;
  logic signed [56:0] t3, u3;
  logic [40:0] dtv3;
  // stage 4
  logic signed [18:0] m0, m1, m3, m4;
  logic [40:0] dth4;
  logic [25:0] e4;
  // stage 5
  logic signed [43:0] rm0, rm1, dm3, dm4, dl0, dl1;
  logic signed [36:0] dh0, dh1;
  logic [25:0] e5;
  // stage 6
  logic signed [63:0] p1x, p2x, p3x, p4x, p1y, p2y, p3y, p4y;
  logic [25:0] e6;
  // stage 7
  logic signed [63:0] mnx, mxx, mny, mxy;
  logic [25:0] e7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[BOX_STAGES-2:0], cin.vld};
    end
    cxd[0] <= cin.cx;
    cyd[0] <= cin.cy;
    czd[0] <= cin.cz;
    for (int i = 1; i < BOX_STAGES-1; i++) begin
      cxd[i] <= cxd[i-1];
      cyd[i] <= cyd[i-1];
      czd[i] <= czd[i-1];
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    logic signed [32:0] ry [0:2];
    logic signed [32:0] rx [0:2];
    logic signed [18:0] cc [0:2];
    for (int k = 0; k < 3; k++) begin
      ry[k] = cin.ch[k].y + 33'sd8192;
      rx[k] = cin.ch[k].x + 33'sd8192;
      cc[k] = cin.ch[k].negc ? -$signed(rx[k][32:14]) : $signed(rx[k][32:14]);
    end
    sz <= $signed(ry[0][32:14]);
    cz <= cc[0];
    sy <= $signed(ry[1][32:14]);
    cy <= cc[1];
    sx <= $signed(ry[2][32:14]);
    cx <= cc[2];
  end

  // stage 2: pairwise products
  always_ff @(posedge clk) begin
    czcy <= 38'(cz) * 38'(cy);
    szcy <= 38'(sz) * 38'(cy);
    szsx <= 38'(sz) * 38'(sx);
    czsx <= 38'(cz) * 38'(sx);
    szcx <= 38'(sz) * 38'(cx);
    czcx <= 38'(cz) * 38'(cx);
    sy2  <= sy;
  end

  // stage 3: triple products
  always_ff @(posedge clk) begin
    t3    <= 57'(szsx) * 57'(sy2);
    u3    <= 57'(czsx) * 57'(sy2);
    czcy3 <= czcy;
    szcy3 <= szcy;
    szcx3 <= szcx;
    czcx3 <= czcx;
    dtv3  <= 41'(view_distance) * 41'(tan_v);
  end

  // stage 4: matrix terms, each rounded once
  always_ff @(posedge clk) begin
    logic signed [63:0] v0, v1;
    logic signed [39:0] v3, v4;
    logic [41:0] ev;
    v0 = (64'(czcy3) <<< 16) - 64'(t3) + 64'sd2147483648;
    v1 = (64'(szcy3) <<< 16) + 64'(u3) + 64'sd2147483648;
    v3 = -40'(szcx3) + 40'sd32768;
    v4 = 40'(czcx3) + 40'sd32768;
    m0 <= $signed(v0[50:32]);
    m1 <= $signed(v1[50:32]);
    m3 <= $signed(v3[34:16]);
    m4 <= $signed(v4[34:16]);
    ev = 42'({height_margin, 16'd0}) + 42'(dtv3) + 42'd32768;
    e4 <= ev[41:16];
    dth4 <= 41'(view_distance) * 41'(tan_h);
  end

  // stage 5: margin and depth times matrix terms
  always_ff @(posedge clk) begin
    logic signed [24:0] rs, ds, ls;
    logic signed [17:0] hs;
    rs = $signed({1'b0, lateral_margin});
    ds = $signed({1'b0, view_distance});
    ls = $signed({1'b0, dth4[23:0]});
    hs = $signed({1'b0, dth4[40:24]});
    rm0 <= 44'(rs) * 44'(m0);
    rm1 <= 44'(rs) * 44'(m1);
    dm3 <= 44'(ds) * 44'(m3);
    dm4 <= 44'(ds) * 44'(m4);
    dl0 <= 44'(ls) * 44'(m0);
    dl1 <= 44'(ls) * 44'(m1);
    dh0 <= 37'(hs) * 37'(m0);
    dh1 <= 37'(hs) * 37'(m1);
    e5  <= e4;
  end

  // stage 6: corners in Q32
  always_ff @(posedge clk) begin
    logic signed [63:0] a0, a1, w0, w1, q3, q4;
    a0 = 64'(rm0) <<< 16;
    a1 = 64'(rm1) <<< 16;
    w0 = a0 + 64'(dl0) + (64'(dh0) <<< 24);
    w1 = a1 + 64'(dl1) + (64'(dh1) <<< 24);
    q3 = 64'(dm3) <<< 16;
    q4 = 64'(dm4) <<< 16;
    p1x <= -a0;
    p2x <= a0;
    p3x <= q3 - w0;
    p4x <= q3 + w0;
    p1y <= -a1;
    p2y <= a1;
    p3y <= q4 - w1;
    p4y <= q4 + w1;
    e6  <= e5;
  end

  // stage 7: extrema
  always_ff @(posedge clk) begin
    mnx <= min4(p1x, p2x, p3x, p4x);
    mxx <= max4(p1x, p2x, p3x, p4x);
    mny <= min4(p1y, p2y, p3y, p4y);
    mxy <= max4(p1y, p2y, p3y, p4y);
    e7  <= e6;
  end

  // stage 8: round to 1/256 m, add camera position, saturate
  always_ff @(posedge clk) begin
    logic signed [63:0] r0, r1, r2, r3;
    logic signed [40:0] es;
    r0 = mnx + 64'sd2147483648;
    r1 = mxx + 64'sd2147483648;
    r2 = mny + 64'sd2147483648;
    r3 = mxy + 64'sd2147483648;
    es = $signed({15'd0, e7});
    x_low  <= sat40(41'(cxd[BOX_STAGES-2]) + 41'($signed(r0[63:32])));
    x_high <= sat40(41'(cxd[BOX_STAGES-2]) + 41'($signed(r1[63:32])));
    y_low  <= sat40(41'(cyd[BOX_STAGES-2]) + 41'($signed(r2[63:32])));
    y_high <= sat40(41'(cyd[BOX_STAGES-2]) + 41'($signed(r3[63:32])));
    z_low  <= sat40(41'(czd[BOX_STAGES-2]) - es);
    z_high <= sat40(41'(czd[BOX_STAGES-2]) + es);
  end

  assign done = vld[BOX_STAGES-1];

endmodule

FILE: hdl/view_frustum_bounding_box_top.sv
// One camera pose per clock cycle, every cycle; busy is high only during
// reset. Each item's bounds appear CORDIC_STAGES + 9 cycles after it is
// taken, for one cycle with done high, and must be captured then. The
// latency is set by the chain of CORDIC cells plus the matrix, corner and
// extrema stages.
// Top level: configuration registers, angle fold, CORDIC cell chain and
// bounds pipeline. Depends on vfb_pkg, vfb_cell, vfb_box.
module view_frustum_bounding_box_top #(
  parameter int CORDIC_STAGES = vfb_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic signed [39:0] cam_x,
  input  logic signed [39:0] cam_y,
  input  logic signed [39:0] cam_z,
  input  logic signed [16:0] azimuth,
  input  logic signed [16:0] roll,
  input  logic signed [16:0] pitch,
  output logic               done,
  output logic signed [39:0] x_low,
  output logic signed [39:0] x_high,
  output logic signed [39:0] y_low,
  output logic signed [39:0] y_high,
  output logic signed [39:0] z_low,
  output logic signed [39:0] z_high
);
  import vfb_pkg::*;

  localparam int LAT = CORDIC_STAGES + BOX_STAGES + 1;

  logic [16:0] tan_h, tan_v;
  logic [23:0] lateral_margin, height_margin, view_distance;
  cell_t       chain [0:CORDIC_STAGES];

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      tan_h          <= 17'd37837;
      tan_v          <= 17'd37837;
      lateral_margin <= 24'd5120;
      height_margin  <= 24'd6400;
      view_distance  <= 24'd0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TAN_H:     tan_h          <= cfg_data[16:0];
        REG_TAN_V:     tan_v          <= cfg_data[16:0];
        REG_LAT_MARG:  lateral_margin <= cfg_data;
        REG_HGT_MARG:  height_margin  <= cfg_data;
        REG_VIEW_DIST: view_distance  <= cfg_data;
        default: ;
      endcase
    end
  end

  // fold angles and load the first cell
  always_ff @(posedge clk) begin
    chain[0].ch[0] <= cordic_init(azimuth);
    chain[0].ch[1] <= cordic_init(roll);
    chain[0].ch[2] <= cordic_init(pitch);
    chain[0].cx    <= cam_x;
    chain[0].cy    <= cam_y;
    chain[0].cz    <= cam_z;
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else begin
      chain[0].vld <= start && !busy;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    vfb_cell #(.IDX(i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .cin  (chain[i]),
      .cout (chain[i+1])
    );
  end

  vfb_box u_box (
    .clk            (clk),
    .rst            (rst),
    .cin            (chain[CORDIC_STAGES]),
    .tan_h          (tan_h),
    .tan_v          (tan_v),
    .lateral_margin (lateral_margin),
    .height_margin  (height_margin),
    .view_distance  (view_distance),
    .done           (done),
    .x_low          (x_low),
    .x_high         (x_high),
    .y_low          (y_low),
    .y_high         (y_high),
    .z_low          (z_low),
    .z_high         (z_high)
  );

  a_done_from_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without an item taken");
  a_x_order: assert property (@(posedge clk) disable iff (rst)
    done |-> x_low <= x_high)
    else $error("x bounds out of order");
  a_y_order: assert property (@(posedge clk) disable iff (rst)
    done |-> y_low <= y_high)
    else $error("y bounds out of order");
  a_z_order: assert property (@(posedge clk) disable iff (rst)
    done |-> z_low <= z_high)
    else $error("z bounds out of order");

endmodule

FILE: bench/vfb_checker.sv
// Bounds checker for the view frustum bounding box: tracks register writes,
// predicts each accepted pose's box and compares it with done results.
// Depends on vfb_pkg.
`timescale 1ns / 100ps
module vfb_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic signed [39:0] cam_x,
  input  logic signed [39:0] cam_y,
  input  logic signed [39:0] cam_z,
  input  logic signed [16:0] azimuth,
  input  logic signed [16:0] roll,
  input  logic signed [16:0] pitch,
  input  logic               done,
  input  logic signed [39:0] x_low,
  input  logic signed [39:0] x_high,
  input  logic signed [39:0] y_low,
  input  logic signed [39:0] y_high,
  input  logic signed [39:0] z_low,
  input  logic signed [39:0] z_high,
  output int                 errors,
  output int                 pending
);
  import vfb_pkg::*;

  typedef struct {
    longint lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  } box_t;

  box_t   boxes_due[$];
  longint tan_h_q, tan_v_q, lat_marg, hgt_marg, view_dist;

  localparam longint ATAN_TAB [24] = '{
    377487360, 222843801, 117744544, 59768969, 30000467, 15014858,
    7509261, 3754860, 1877459, 938733, 469367, 234683,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};

  function automatic longint round_q(input longint v, input int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clip40(input longint v);
    if (v > 64'sd549755813887) return 64'sd549755813887;
    if (v < -64'sd549755813888) return -64'sd549755813888;
    return v;
  endfunction

  // Sine and cosine in Q16 from an angle in 1/128 degree.
  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint r, x, y, z, dx, dy;
    bit     flip;
    r = ang % 46080;
    flip = 0;
    if (r < 0) r += 46080;
    if (r >= 23040) r -= 46080;
    if (r > 11520) begin
      r = 23040 - r;
      flip = 1;
    end else if (r < -11520) begin
      r = -23040 - r;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    z = r * 65536;
    for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    s = round_q(y, 14);
    c = round_q(x, 14);
    if (flip) c = -c;
  endfunction

  function automatic box_t bounds_of(input longint px, py, pz, az, rl, pt);
    longint sz, cz, sy, cy, sx, cx, m0, m1, m3, m4, rr, dd, xw, e;
    longint ax[4], ay[4], mnx, mxx, mny, mxy;
    box_t   b;
    sin_cos(az, sz, cz);
    sin_cos(rl, sy, cy);
    sin_cos(pt, sx, cx);
    m0 = round_q(cz * cy * 65536 - sz * sx * sy, 32);
    m1 = round_q(sz * cy * 65536 + cz * sx * sy, 32);
    m3 = round_q(-(sz * cx), 16);
    m4 = round_q(cz * cx, 16);
    rr = lat_marg * 65536;
    dd = view_dist * 65536;
    xw = rr + view_dist * tan_h_q;
    ax[0] = -rr * m0;           ay[0] = -rr * m1;
    ax[1] = rr * m0;            ay[1] = rr * m1;
    ax[2] = -xw * m0 + dd * m3; ay[2] = -xw * m1 + dd * m4;
    ax[3] = xw * m0 + dd * m3;  ay[3] = xw * m1 + dd * m4;
    mnx = ax[0]; mxx = ax[0]; mny = ay[0]; mxy = ay[0];
    for (int j = 1; j < 4; j++) begin
      if (ax[j] < mnx) mnx = ax[j];
      if (ax[j] > mxx) mxx = ax[j];
      if (ay[j] < mny) mny = ay[j];
      if (ay[j] > mxy) mxy = ay[j];
    end
    e = round_q(hgt_marg * 65536 + view_dist * tan_v_q, 16);
    b.lo_x = clip40(px + round_q(mnx, 32));
    b.hi_x = clip40(px + round_q(mxx, 32));
    b.lo_y = clip40(py + round_q(mny, 32));
    b.hi_y = clip40(py + round_q(mxy, 32));
    b.lo_z = clip40(pz - e);
    b.hi_z = clip40(pz + e);
    return b;
  endfunction

  task automatic report(input string fld, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", fld, got, want, $realtime);
    errors++;
  endtask

  assign pending = boxes_due.size();

  always @(posedge clk) begin
    box_t b;
    if (rst) begin
      errors = 0;
      tan_h_q <= 37837; tan_v_q <= 37837;
      lat_marg <= 5120; hgt_marg <= 6400; view_dist <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_TAN_H:     tan_h_q <= cfg_data[16:0];
          REG_TAN_V:     tan_v_q <= cfg_data[16:0];
          REG_LAT_MARG:  lat_marg <= cfg_data;
          REG_HGT_MARG:  hgt_marg <= cfg_data;
          REG_VIEW_DIST: view_dist <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        boxes_due.push_back(bounds_of(cam_x, cam_y, cam_z, azimuth, roll, pitch));
      if (done) begin
        if (boxes_due.size() == 0) begin
          report("done", 1, 0);
        end else begin
          b = boxes_due.pop_front();
          if (x_low != b.lo_x) report("x_low", x_low, b.lo_x);
          if (x_high != b.hi_x) report("x_high", x_high, b.hi_x);
          if (y_low != b.lo_y) report("y_low", y_low, b.lo_y);
          if (y_high != b.hi_y) report("y_high", y_high, b.hi_y);
          if (z_low != b.lo_z) report("z_low", z_low, b.lo_z);
          if (z_high != b.hi_z) report("z_high", z_high, b.hi_z);
        end
      end
    end
  end
endmodule

FILE: bench/tb.sv
// Top of the bench: clock, reset, pose and register stimulus, verdict.
// Depends on vfb_pkg, view_frustum_bounding_box_top and vfb_checker.
`timescale 1ns / 100ps
module tb;
  import vfb_pkg::*;

  logic               clk = 0, rst = 1, start = 0, busy, done;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;
  logic signed [39:0] cam_x = '0, cam_y = '0, cam_z = '0;
  logic signed [16:0] azimuth = '0, roll = '0, pitch = '0;
  logic signed [39:0] x_low, x_high, y_low, y_high, z_low, z_high;
  int                 errors, pending, cycles = 0;
  bit                 calm = 0;

  localparam logic signed [39:0] POS_MAX = 40'sh7FFFFFFFFF;
  localparam logic signed [39:0] POS_MIN = 40'sh8000000000;
  // index past the last register, writes to it are dropped
  localparam logic [2:0]         REG_UNUSED = 3'd5;

  always #6 clk = ~clk;

  view_frustum_bounding_box_top i_dut (.*);
  vfb_checker i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [39:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return 40'({$urandom, $urandom});
      1: return $urandom_range(0, 1) ? POS_MAX - 40'($urandom_range(0, 40000))
                                     : POS_MIN + 40'($urandom_range(0, 40000));
      default: return 40'(signed'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic signed [16:0] rand_ang();
    return 17'(signed'($urandom_range(0, 92160)) - 46080);
  endfunction

  // Present one pose, hold it until taken, then maybe idle a burst.
  task automatic send_pose(input logic signed [39:0] px, py, pz,
                           input logic signed [16:0] az, rl, pt);
    start <= 1;
    cam_x <= px; cam_y <= py; cam_z <= pz;
    azimuth <= az; roll <= rl; pitch <= pt;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_poses(input int n);
    for (int k = 0; k < n; k++)
      send_pose(rand_pos(), rand_pos(), rand_pos(), rand_ang(), rand_ang(), rand_ang());
  endtask

  initial begin
    logic signed [16:0] angs[12];
    angs = '{0, 46080, -46080, 23040, -23040, 11520, -11520, 11521, -11521,
             23039, -23041, 34560};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // reset registers, zero view distance
    foreach (angs[k]) send_pose(0, 0, 0, angs[k], angs[(k + 3) % 12], angs[(k + 7) % 12]);
    send_pose(POS_MAX, POS_MAX, POS_MAX, 0, 0, 0);
    send_pose(POS_MIN, POS_MIN, POS_MIN, 23040, 0, 0);
    drain();
    write_reg(REG_VIEW_DIST, 24'd25600);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    foreach (angs[k]) send_pose(1000, -1000, 0, angs[k], angs[(k + 5) % 12], angs[k]);
    send_pose(POS_MAX, POS_MIN, POS_MAX, 5760, 0, 0);
    random_poses(200);
    drain();
    // every register at its maximum
    write_reg(REG_TAN_H, 24'hFFFFFF);
    write_reg(REG_TAN_V, 24'h01FFFF);
    write_reg(REG_LAT_MARG, 24'hFFFFFF);
    write_reg(REG_HGT_MARG, 24'hFFFFFF);
    write_reg(REG_VIEW_DIST, 24'hFFFFFF);
    random_poses(200);
    drain();
    // every register at zero
    write_reg(REG_TAN_H, 0);
    write_reg(REG_TAN_V, 0);
    write_reg(REG_LAT_MARG, 0);
    write_reg(REG_HGT_MARG, 0);
    write_reg(REG_VIEW_DIST, 0);
    random_poses(200);
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(REG_TAN_H, 24'($urandom));
      write_reg(REG_TAN_V, 24'($urandom));
      write_reg(REG_LAT_MARG,
                24'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 20000)));
      write_reg(REG_HGT_MARG, 24'($urandom));
      write_reg(REG_VIEW_DIST,
                24'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 60000)));
      calm = (ph == 3);
      random_poses(190);
    end
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
